// ===== rtl/cra_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cra_pkg
// Widths and constants shared by the capped running average block, its
// channel interfaces and its checker.
// ----------------------------------------------------------------------------
package cra_pkg;

	localparam int SAMPLE_W = 32;                  // raw duration sample
	localparam int AVG_W    = 16;                  // average, count and cap

	localparam logic [AVG_W-1:0] SAT_LIMIT = '1;   // saturation ceiling
	localparam logic [AVG_W-1:0] CAP_RESET = 16'd64;

endpackage

// ===== rtl/cra_channels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cra_channels
// Valid/ready channel interfaces: sample input, result output and the
// configuration write channel.
// ----------------------------------------------------------------------------
interface cra_sample_if;
	logic                         valid;
	logic                         ready;
	logic [cra_pkg::SAMPLE_W-1:0] sample_seconds;

	modport source (output valid, output sample_seconds, input ready);
	modport sink   (input valid, input sample_seconds, output ready);
	modport mon    (input valid, input sample_seconds, input ready);
endinterface

interface cra_result_if;
	logic                      valid;
	logic                      ready;
	logic [cra_pkg::AVG_W-1:0] average_seconds;
	logic [cra_pkg::AVG_W-1:0] sample_count;

	modport source (output valid, output average_seconds, output sample_count, input ready);
	modport sink   (input valid, input average_seconds, input sample_count, output ready);
	modport mon    (input valid, input average_seconds, input sample_count, input ready);
endinterface

interface cra_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [cra_pkg::AVG_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
	modport mon    (input valid, input data, input ready);
endinterface

// ===== rtl/capped_running_average_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capped_running_average_top
// Running average of duration samples: cumulative until the count reaches
// sample_cap, then a bounded moving average with a step of at least one.
// ----------------------------------------------------------------------------
//
//  channel   dir   payload                          transaction
//  --------  ----  -------------------------------  ---------------------------
//  samples   in    sample_seconds[31:0]             one sample per transaction
//  results   out   average_seconds, sample_count    one result per sample
//  cfg       in    data[15:0] (sample_cap)          one register write
//
//  From a sample transaction to the result register: a zero sample, a restart
//  or a capped sample equal to the average goes straight to the final state;
//  a capped step passes through the divider; a cumulative step takes a
//  multiply state ahead of the divider. samples.ready returns as the result
//  is loaded, so a sample holds the block until then. The shared restoring
//  divider, one quotient bit a cycle, sets the cost.
//  samples.ready is high only while the sequencer is idle.
//  A finished result waits in the output register while the next sample is
//  taken; the sequencer stalls in its final state only if that register is full.
//  arst_n clears the average, the count and all control; sample_cap goes to 64.
//  cfg.ready is always high.
// ----------------------------------------------------------------------------
module capped_running_average_top (
	input  logic               clk,
	input  logic               arst_n,
	cra_sample_if.sink         samples,
	cra_result_if.source       results,
	cra_cfg_if.sink            cfg
);

	localparam int W      = cra_pkg::AVG_W;
	localparam int SW     = cra_pkg::SAMPLE_W;
	localparam int STEP_W = $clog2(SW);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SW - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t           state_q;
	logic             cum_q;         // divider result feeds the cumulative path
	logic             neg_q;         // capped step direction
	logic [W-1:0]     sample_q;      // saturated sample
	logic [W-1:0]     avg_q;
	logic [W-1:0]     cnt_q;
	logic [W-1:0]     cap_q;
	logic [W:0]       divisor_q;
	logic [W:0]       rem_q;
	logic [SW-1:0]    quo_q;         // dividend shifts out, quotient shifts in
	logic [STEP_W-1:0] step_q;
	logic             out_valid_q;
	logic [W-1:0]     out_avg_q;
	logic [W-1:0]     out_cnt_q;

	logic             take;
	logic             load_out;
	logic [W-1:0]     sat;
	logic [W:0]       diff;
	logic [W-1:0]     mag;
	logic [W+1:0]     trial;
	logic             qbit;
	logic [W:0]       rem_next;
	logic [SW-1:0]    quo_next;
	logic [W-1:0]     step_mag;

	assign samples.ready   = (state_q == ST_IDLE);
	assign cfg.ready       = 1'b1;
	assign results.valid   = out_valid_q;
	assign results.average_seconds = out_avg_q;
	assign results.sample_count    = out_cnt_q;

	assign take = samples.valid && samples.ready;

	// Load the result once the output register is free.
	assign load_out = (state_q == ST_FIN) && (!out_valid_q || results.ready);

	// Saturate the raw sample to the average's width.
	assign sat = (samples.sample_seconds > SW'(cra_pkg::SAT_LIMIT))
		? cra_pkg::SAT_LIMIT : samples.sample_seconds[W-1:0];

	// Signed difference for the capped path and its magnitude.
	assign diff = {1'b0, sat} - {1'b0, avg_q};
	assign mag  = diff[W] ? W'(-diff) : diff[W-1:0];

	// One restoring divide step: bring down the next dividend bit, try to subtract.
	assign trial    = {rem_q, quo_q[SW-1]};
	assign qbit     = (trial >= {1'b0, divisor_q});
	assign rem_next = qbit ? (W+1)'(trial - {1'b0, divisor_q}) : trial[W:0];
	assign quo_next = {quo_q[SW-2:0], qbit};

	// Capped step is forced to at least one when the difference is nonzero.
	assign step_mag = (quo_next[W-1:0] == '0) ? W'(1) : quo_next[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cum_q       <= 1'b0;
			neg_q       <= 1'b0;
			sample_q    <= '0;
			avg_q       <= '0;
			cnt_q       <= '0;
			cap_q       <= cra_pkg::CAP_RESET;
			divisor_q   <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			out_avg_q   <= '0;
			out_cnt_q   <= '0;
		end else begin
			// Register write: taken whenever offered.
			if (cfg.valid && cfg.ready) begin
				cap_q <= cfg.data;
			end

			// Load a finished result, else drop the one the sink takes.
			if (load_out) begin
				out_valid_q <= 1'b1;
				out_avg_q   <= avg_q;
				out_cnt_q   <= cnt_q;
			end else if (results.valid && results.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (take) begin
						sample_q <= sat;
						rem_q    <= '0;
						step_q   <= '0;
						if (samples.sample_seconds == '0) begin
							// Zero sample: hold state, just report it.
							state_q <= ST_FIN;
						end else if (cnt_q == '0 || avg_q == '0) begin
							// Restart the average from this sample.
							avg_q   <= sat;
							cnt_q   <= W'(1);
							state_q <= ST_FIN;
						end else if (cnt_q < cap_q) begin
							cum_q   <= 1'b1;
							state_q <= ST_MUL;
						end else if (diff == '0) begin
							// Capped and equal to the average: nothing moves.
							state_q <= ST_FIN;
						end else begin
							cum_q     <= 1'b0;
							neg_q     <= diff[W];
							quo_q     <= SW'(mag);
							divisor_q <= {1'b0, cap_q} + (W+1)'(1);
							state_q   <= ST_DIV;
						end
					end
				end

				ST_MUL: begin
					// Weighted sum avg*count + sample fits the dividend exactly.
					quo_q     <= SW'(avg_q) * SW'(cnt_q) + SW'(sample_q);
					divisor_q <= {1'b0, cnt_q} + (W+1)'(1);
					state_q   <= ST_DIV;
				end

				ST_DIV: begin
					rem_q  <= rem_next;
					quo_q  <= quo_next;
					step_q <= step_q + STEP_W'(1);
					if (step_q == LAST_STEP) begin
						if (cum_q) begin
							avg_q <= quo_next[W-1:0];
							cnt_q <= cnt_q + W'(1);
						end else if (neg_q) begin
							avg_q <= avg_q - step_mag;
						end else begin
							avg_q <= avg_q + step_mag;
						end
						state_q <= ST_FIN;
					end
				end

				ST_FIN: begin
					// Advance once the result is loaded.
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/cra_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cra_checker
// Port-level checks for the capped running average block, bound to the top.
// ----------------------------------------------------------------------------
module cra_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      sample_valid,
	input  logic                      sample_ready,
	input  logic                      result_valid,
	input  logic                      result_ready,
	input  logic [cra_pkg::AVG_W-1:0] result_avg,
	input  logic [cra_pkg::AVG_W-1:0] result_cnt
);

	// The sequencer is busy in the cycle after each sample transaction.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("samples.ready high right after a sample transaction");

	// A stalled result holds.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid
			&& $stable(result_avg) && $stable(result_cnt))
		else $error("stalled result changed");

	// Average is zero exactly when no sample has been averaged yet.
	a_zero_pair: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((result_avg == '0) == (result_cnt == '0)))
		else $error("average and count disagree on emptiness");

	// A result never appears in the cycle right after a sample transaction.
	a_no_same_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !$past(sample_valid && sample_ready))
		else $error("result appeared too early");

endmodule

bind capped_running_average_top cra_checker u_cra_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (samples.valid),
	.sample_ready (samples.ready),
	.result_valid (results.valid),
	.result_ready (results.ready),
	.result_avg   (results.average_seconds),
	.result_cnt   (results.sample_count)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for capped_running_average_top. An in-bench predictor
// tracks the running average, the sample count and the cap, and queues one
// expected (average, count) pair per accepted sample. Each result is then
// compared with the oldest pair in that queue. Directed tests cover the
// restart, saturation, zero samples and every cap regime. Random phases
// follow, each with a fresh cap, while the sender idles in bursts and the
// receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb;

	// Generous ceiling; the slowest correct run needs well under 1 ms.
	localparam int RUN_LIMIT_NS = 8_000_000;
	localparam int SETTLE_CYCLES = 40;          // above the slowest sample-to-result path
	localparam int REPORT_LIMIT = 200;          // keep a broken run's log readable
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_SAMPLES = 120;

	typedef struct packed {
		logic [cra_pkg::AVG_W-1:0] avg;
		logic [cra_pkg::AVG_W-1:0] count;
	} avg_report_t;

	// Receiver stall patterns
	typedef enum logic [1:0] {
		RX_OPEN,     // always ready
		RX_COIN,     // ready half of the time
		RX_SPARSE,   // ready one cycle in four on average
		RX_BLOCKS    // regular stalled blocks, while rx_tick[5:3] is zero
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	cra_sample_if samples_ch ();
	cra_result_if results_ch ();
	cra_cfg_if    cfg_ch ();

	capped_running_average_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.results (results_ch),
		.cfg     (cfg_ch)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Predictor state: a private copy of what the block should hold
	// ------------------------------------------------------------------------
	logic [cra_pkg::AVG_W-1:0] pred_avg;
	logic [cra_pkg::AVG_W-1:0] pred_count;
	logic [cra_pkg::AVG_W-1:0] pred_cap;

	// Expected (average, count) pairs, oldest first
	avg_report_t awaited_reports[$];

	int error_count = 0;
	int reports_checked = 0;
	int samples_sent = 0;
	int cap_writes = 0;
	int n_zero = 0;
	int n_saturated = 0;
	int n_restart = 0;
	int n_cumulative = 0;
	int n_capped = 0;
	int n_capped_held = 0;
	int n_forced_step = 0;

	// Sender burst control
	int gap_max = 4;
	int burst_left = 0;

	// Advance the predicted average by one sample and queue the result.
	task automatic predict_average(input logic [cra_pkg::SAMPLE_W-1:0] raw);
		logic [cra_pkg::AVG_W-1:0] sat;
		logic [63:0] total;
		int delta;
		int step;
		if (raw == '0) begin
			n_zero++;
		end else begin
			if (raw > {16'b0, cra_pkg::SAT_LIMIT}) begin
				sat = cra_pkg::SAT_LIMIT;
				n_saturated++;
			end else begin
				sat = raw[cra_pkg::AVG_W-1:0];
			end
			if (pred_count == '0 || pred_avg == '0) begin
				// Empty history: start afresh from this sample
				pred_avg = sat;
				pred_count = 16'd1;
				n_restart++;
			end else if (pred_count < pred_cap) begin
				// True cumulative average over an exact wide sum
				total = 64'(pred_avg) * 64'(pred_count) + 64'(sat);
				pred_avg = cra_pkg::AVG_W'(total / (64'(pred_count) + 64'd1));
				pred_count = pred_count + 16'd1;
				n_cumulative++;
			end else begin
				// Capped: move by delta/(cap+1), at least one unit
				n_capped++;
				delta = int'(sat) - int'(pred_avg);
				if (delta == 0) begin
					n_capped_held++;
				end else begin
					step = delta / (int'(pred_cap) + 1);
					if (step == 0) begin
						step = (delta > 0) ? 1 : -1;
						n_forced_step++;
					end
					pred_avg = pred_avg + cra_pkg::AVG_W'(step);
				end
			end
		end
		awaited_reports.push_back('{avg: pred_avg, count: pred_count});
	endtask

	// ------------------------------------------------------------------------
	// Sample channel driver: bursts of random length with random gaps
	// ------------------------------------------------------------------------
	task automatic send_sample(input logic [cra_pkg::SAMPLE_W-1:0] raw);
		int gap;
		if (burst_left == 0) begin
			gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
			if (gap != 0) begin
				samples_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(12, 1);
		end
		burst_left--;
		samples_ch.valid          <= 1'b1;
		samples_ch.sample_seconds <= raw;
		do @(posedge clk); while (!samples_ch.ready);
		samples_sent++;
		predict_average(raw);
	endtask

	// Drop valid and hold until every queued result has been checked.
	task automatic drain_results();
		samples_ch.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (awaited_reports.size() != 0);
	endtask

	// Write sample_cap; callers drain first so the block is idle.
	task automatic write_cap(input logic [cra_pkg::AVG_W-1:0] cap);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= cap;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		pred_cap = cap;
		cap_writes++;
	endtask

	// ------------------------------------------------------------------------
	// Result checker: compare each result transaction with the oldest pair
	// ------------------------------------------------------------------------
	avg_report_t want;

	always @(posedge clk) begin
		if (arst_n && results_ch.valid && results_ch.ready) begin
			if (awaited_reports.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_LIMIT)
					$display("%0t: result with none awaited: expected nothing, actual avg %0d count %0d",
						$time, results_ch.average_seconds, results_ch.sample_count);
			end else begin
				want = awaited_reports.pop_front();
				reports_checked++;
				if (results_ch.average_seconds !== want.avg) begin
					error_count++;
					if (error_count <= REPORT_LIMIT)
						$display("%0t: average_seconds expected %0d, actual %0d",
							$time, want.avg, results_ch.average_seconds);
				end
				if (results_ch.sample_count !== want.count) begin
					error_count++;
					if (error_count <= REPORT_LIMIT)
						$display("%0t: sample_count expected %0d, actual %0d",
							$time, want.count, results_ch.sample_count);
				end
				if (error_count == REPORT_LIMIT)
					$display("%0t: further reports suppressed", $time);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver stall pattern: random modes held for random stretches
	// ------------------------------------------------------------------------
	rx_mode_t rx_mode = RX_OPEN;
	int rx_left = 0;
	logic [5:0] rx_tick = '0;

	initial begin
		results_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(3, 0));
				rx_left = $urandom_range(400, 50);
			end
			rx_left--;
			rx_tick++;
			case (rx_mode)
				RX_OPEN:   results_ch.ready <= 1'b1;
				RX_COIN:   results_ch.ready <= ($urandom_range(1, 0) == 1);
				RX_SPARSE: results_ch.ready <= ($urandom_range(3, 0) == 0);
				default:   results_ch.ready <= (rx_tick[5:3] != 3'b000);
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Reset cap of 64: zero on empty state, restart, ignored zero,
	// saturation of every oversized sample, and the first cumulative steps.
	task automatic test_restart_and_saturation();
		gap_max = 3;
		send_sample(32'd0);
		send_sample(32'd1);
		send_sample(32'd0);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'h0001_0000);
		send_sample(32'd65535);
		send_sample(32'h8000_0000);
	endtask

	// Cap lowered below the count: capped mode with the count held,
	// an equal sample, large steps both ways, and forced one-unit steps.
	task automatic test_capped_steps();
		drain_results();
		write_cap(16'd1);
		send_sample({16'b0, pred_avg});
		send_sample(32'd1);
		send_sample(32'd65535);
		send_sample({16'b0, pred_avg} + 32'd1);
		send_sample({16'b0, pred_avg} - 32'd1);
	endtask

	// Cap of zero makes the average jump to each sample; the top cap of
	// 65535 returns the block to cumulative averaging.
	task automatic test_cap_extremes();
		drain_results();
		write_cap(16'd0);
		send_sample(32'd7);
		send_sample(32'd65535);
		send_sample(32'd1);
		drain_results();
		write_cap(16'hFFFF);
		send_sample(32'd3);
		send_sample(32'd60000);
		send_sample(32'd0);
	endtask

	// Random phases: a fresh cap and sender rate per phase, samples
	// weighted toward the current average so the capped steps get exercised.
	task automatic test_random_phases();
		logic [cra_pkg::AVG_W-1:0] cap;
		logic [cra_pkg::SAMPLE_W-1:0] raw;
		int near;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain_results();
			case ($urandom_range(9, 0))
				0:       cap = 16'd0;
				1:       cap = 16'd1;
				2, 3:    cap = cra_pkg::AVG_W'($urandom_range(8, 2));
				4, 5:    cap = cra_pkg::AVG_W'($urandom_range(64, 9));
				6:       cap = 16'hFFFF;
				7:       cap = cra_pkg::AVG_W'($urandom);
				default: cap = cra_pkg::AVG_W'($urandom_range(32, 2));
			endcase
			write_cap(cap);
			// Every third phase runs the sender flat out
			gap_max = (ph % 3 == 1) ? 0 : $urandom_range(8, 1);
			for (int i = 0; i < PHASE_SAMPLES; i++) begin
				case ($urandom_range(99, 0)) inside
					[0:9]:   raw = '0;
					[10:19]: raw = $urandom;
					[20:24]: raw = ($urandom_range(1, 0) == 1) ? 32'd65535
						: 32'h0001_0000 + $urandom_range(32'hFFFF, 0);
					[25:54]: begin
						near = int'(pred_avg) + int'($urandom_range(6, 0)) - 3;
						raw = (near < 0) ? 32'd0 : 32'(near);
					end
					[55:79]: raw = $urandom_range(300, 1);
					default: raw = {16'b0, cra_pkg::AVG_W'($urandom)};
				endcase
				send_sample(raw);
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequencer: reset once, run the tests, settle, report
	// ------------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		samples_ch.valid = 1'b0;
		samples_ch.sample_seconds = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		pred_avg = '0;
		pred_count = '0;
		pred_cap = cra_pkg::CAP_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_restart_and_saturation();
		test_capped_steps();
		test_cap_extremes();
		test_random_phases();

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (awaited_reports.size() != 0)
			error_count++;

		$display("Covered %0d samples: %0d zero, %0d saturated, %0d restarts, %0d cumulative",
			samples_sent, n_zero, n_saturated, n_restart, n_cumulative);
		$display("%0d capped (%0d held, %0d forced +/-1), %0d cap writes, %0d results checked",
			n_capped, n_capped_held, n_forced_step, cap_writes, reports_checked);
		if (error_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Hard stop if the handshakes never complete
	initial begin
		#(RUN_LIMIT_NS);
		$display("%0t: timeout with %0d results still awaited", $time, awaited_reports.size());
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/cra_pkg.sv
rtl/cra_channels.sv
rtl/capped_running_average_top.sv
rtl/cra_checker.sv
tb/tb.sv
